>>> rtl/orbit_follow_controller_core_defines.svh
// Assertion macros shared by the orbit follow controller RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ORBIT_FOLLOW_CONTROLLER_CORE_DEFINES_SVH
`define ORBIT_FOLLOW_CONTROLLER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// checked outside reset
`define OFC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define OFC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OFC_ASSERT(label, clk, rst, prop, msg)
`define OFC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

>>> rtl/ofc_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes, reset values and payload types of the orbit follow controller.
// No dependencies.
package ofc_pkg;

   localparam int DIST_W    = 10;
   localparam int MPW_W     = 4;
   localparam int MODE_W    = 4;
   localparam int MOVE_W    = 2;
   localparam int COL_W     = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 10;

   // item kind
   localparam logic FUNC_TICK   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   // move commands
   localparam logic [MOVE_W-1:0] MV_NONE  = 2'd0;
   localparam logic [MOVE_W-1:0] MV_FWD   = 2'd1;
   localparam logic [MOVE_W-1:0] MV_LEFT  = 2'd2;
   localparam logic [MOVE_W-1:0] MV_RIGHT = 2'd3;

   // LED colours
   localparam logic [COL_W-1:0] COL_BLUE  = 2'd0;
   localparam logic [COL_W-1:0] COL_RED   = 2'd1;
   localparam logic [COL_W-1:0] COL_GREEN = 2'd2;

   // controller states, reported as mode
   localparam logic [MODE_W-1:0] ST_MEASURE    = 4'd0;
   localparam logic [MODE_W-1:0] ST_CHECK      = 4'd1;
   localparam logic [MODE_W-1:0] ST_CLOSE      = 4'd2;
   localparam logic [MODE_W-1:0] ST_ESCAPE     = 4'd3;
   localparam logic [MODE_W-1:0] ST_GREATER    = 4'd4;
   localparam logic [MODE_W-1:0] ST_SMALLER    = 4'd5;
   localparam logic [MODE_W-1:0] ST_WAIT       = 4'd6;
   localparam logic [MODE_W-1:0] ST_MEAS_AGAIN = 4'd7;
   localparam logic [MODE_W-1:0] ST_WAIT_AGAIN = 4'd8;
   localparam logic [MODE_W-1:0] ST_UPD_MIN    = 4'd9;
   localparam logic [MODE_W-1:0] ST_MEAS_ESC   = 4'd10;
   localparam logic [MODE_W-1:0] ST_WAIT_ESC   = 4'd11;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DESIRED   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MARGIN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOO_CLOSE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTATE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MPW       = 3'd4;

   localparam logic [DIST_W-1:0] WINDOW_START = 10'd1000;

   localparam logic [DIST_W-1:0] RST_DESIRED   = 10'd65;
   localparam logic [DIST_W-1:0] RST_MARGIN    = 10'd5;
   localparam logic [DIST_W-1:0] RST_TOO_CLOSE = 10'd45;
   localparam logic [DIST_W-1:0] RST_ROTATE    = 10'd12;
   localparam logic [MPW_W-1:0]  RST_MPW       = 4'd1;

   typedef struct packed {
      logic              func;
      logic [DIST_W-1:0] distance_sample;
   } item_type;

   typedef struct packed {
      logic [MOVE_W-1:0] move_cmd;
      logic [COL_W-1:0]  led_color;
      logic [MODE_W-1:0] mode;
   } result_type;

   typedef struct packed {
      logic [DIST_W-1:0] target_dist;
      logic [DIST_W-1:0] margin;
      logic [DIST_W-1:0] too_close_limit;
      logic [DIST_W-1:0] rotate_threshold;
      logic [MPW_W-1:0]  messages_per_window;
   } cfg_type;

endpackage

>>> rtl/ofc_req_if.sv
`timescale 1ns / 1ps
// Input channel: control tick or distance sample, valid/ready handshake.
// Depends on ofc_pkg.
interface ofc_req_if import ofc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              func;
   logic [DIST_W-1:0] distance_sample;

   modport source (output valid, output func, output distance_sample, input ready);
   modport sink   (input valid, input func, input distance_sample, output ready);
endinterface

>>> rtl/ofc_rsp_if.sv
`timescale 1ns / 1ps
// Result channel: move command, LED colour and mode, valid/ready handshake.
// Depends on ofc_pkg.
interface ofc_rsp_if import ofc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MOVE_W-1:0] move_cmd;
   logic [COL_W-1:0]  led_color;
   logic [MODE_W-1:0] mode;

   modport source (output valid, output move_cmd, output led_color, output mode,
                   input ready);
   modport sink   (input valid, input move_cmd, input led_color, input mode,
                   output ready);
endinterface

>>> rtl/ofc_csr_if.sv
`timescale 1ns / 1ps
// Register write channel: index and data, valid/ready handshake.
// Depends on ofc_pkg.
interface ofc_csr_if import ofc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/ofc_engine.sv
`timescale 1ns / 1ps
// Controller state machine, sample window and minimum tracking.
// Depends on ofc_pkg and orbit_follow_controller_core_defines.svh.
`include "orbit_follow_controller_core_defines.svh"

module ofc_engine
   import ofc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type res
);

   logic [MODE_W-1:0] state_ff, state_in;
   logic [DIST_W-1:0] cur_dist_ff, cur_dist_in;
   logic [DIST_W-1:0] min_seen_ff, min_seen_in;
   logic [MPW_W-1:0]  rx_count_ff, rx_count_in;
   logic [COL_W-1:0]  color_ff, color_in;
   logic [MOVE_W-1:0] move;

   logic [DIST_W-1:0] base_dist;
   logic              window_full;
   logic [DIST_W-1:0] min_upd;
   logic [DIST_W-1:0] rise;
   logic [DIST_W:0]   esc_sum;

   // first sample of a window starts from the preset
   assign base_dist   = (rx_count_ff == '0) ? WINDOW_START : cur_dist_ff;
   assign window_full = (rx_count_ff == cfg.messages_per_window);
   assign min_upd     = (cur_dist_ff < min_seen_ff) ? cur_dist_ff : min_seen_ff;
   assign rise        = cur_dist_ff - min_upd;
   assign esc_sum     = {1'b0, cur_dist_ff} + {1'b0, cfg.margin};

   always_comb begin
      state_in    = state_ff;
      cur_dist_in = cur_dist_ff;
      min_seen_in = min_seen_ff;
      rx_count_in = rx_count_ff;
      color_in    = color_ff;
      move        = MV_NONE;
      if (item.func == FUNC_SAMPLE) begin
         cur_dist_in = base_dist;
         if (!window_full) begin
            if (item.distance_sample < base_dist) begin
               cur_dist_in = item.distance_sample;
            end
            rx_count_in = rx_count_ff + 1'b1;
         end
      end else begin
         unique case (state_ff)
            ST_MEASURE: begin
               rx_count_in = '0;
               state_in    = ST_WAIT;
            end
            ST_WAIT: begin
               if (window_full) state_in = ST_CHECK;
            end
            ST_CHECK: begin
               if (cur_dist_ff < cfg.too_close_limit) begin
                  state_in    = ST_CLOSE;
                  min_seen_in = cur_dist_ff;
               end else if (cur_dist_ff > cfg.target_dist) begin
                  state_in = ST_GREATER;
               end else begin
                  state_in = ST_SMALLER;
               end
            end
            ST_CLOSE: begin
               color_in = COL_RED;
               move     = MV_LEFT;
               state_in = ST_MEAS_AGAIN;
            end
            ST_MEAS_AGAIN: begin
               rx_count_in = '0;
               state_in    = ST_WAIT_AGAIN;
            end
            ST_WAIT_AGAIN: begin
               if (window_full) state_in = ST_UPD_MIN;
            end
            ST_UPD_MIN: begin
               min_seen_in = min_upd;
               state_in    = (rise > cfg.rotate_threshold) ? ST_ESCAPE : ST_CLOSE;
            end
            ST_ESCAPE: begin
               // wide sum, so a large margin always ends the escape
               if (esc_sum > {1'b0, cfg.target_dist}) begin
                  state_in = ST_MEASURE;
               end else begin
                  move     = MV_FWD;
                  state_in = ST_MEAS_ESC;
               end
            end
            ST_MEAS_ESC: begin
               rx_count_in = '0;
               state_in    = ST_WAIT_ESC;
            end
            ST_WAIT_ESC: begin
               if (window_full) state_in = ST_ESCAPE;
            end
            ST_GREATER: begin
               move     = MV_RIGHT;
               color_in = COL_GREEN;
               state_in = ST_MEASURE;
            end
            ST_SMALLER: begin
               move     = MV_LEFT;
               color_in = COL_RED;
               state_in = ST_MEASURE;
            end
            default: begin
               state_in = state_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_MEASURE;
         cur_dist_ff <= '0;
         min_seen_ff <= '0;
         rx_count_ff <= '0;
         color_ff    <= COL_BLUE;
      end else if (step) begin
         state_ff    <= state_in;
         cur_dist_ff <= cur_dist_in;
         min_seen_ff <= min_seen_in;
         rx_count_ff <= rx_count_in;
         color_ff    <= color_in;
      end
   end

   assign res.move_cmd  = move;
   assign res.led_color = color_in;
   assign res.mode      = state_in;

   `OFC_ASSERT(a_full_window_ignores, clock, reset, step && item.func == FUNC_SAMPLE && window_full |=> $stable(rx_count_ff), "sample taken into a full window")
   `OFC_ASSERT(a_cur_dist_bounded, clock, reset, cur_dist_ff <= WINDOW_START, "running minimum above window preset")
   `OFC_ASSERT(a_min_after_update, clock, reset, step && item.func == FUNC_TICK && state_ff == ST_UPD_MIN |=> min_seen_ff <= cur_dist_ff, "tracked minimum above current distance")

endmodule

>>> rtl/orbit_follow_controller_core.sv
`timescale 1ns / 1ps
// Path: a transaction accepted into the input register passes through the engine logic and
// is captured in the result register, where it waits until the result side takes it.
// Throughput: one transaction per cycle while the result side does not stall; input register and
// result register each take a new transaction while the one ahead moves on, and the engine state updates with it.
// Reset (synchronous, active high): state measure, distances and count zero, LED blue,
// registers back to 65 / 5 / 45 / 12 / 1.
// Depends on ofc_pkg, the channel interfaces, ofc_engine and the defines header.
`include "orbit_follow_controller_core_defines.svh"

module orbit_follow_controller_core
   import ofc_pkg::*;
(
   input logic      clock,
   input logic      reset,
   ofc_req_if.sink  req_chan,
   ofc_rsp_if.source rsp_chan,
   ofc_csr_if.sink  csr_chan
);

   cfg_type    cfg_ff, cfg_in;
   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff, in_item_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_res_ff, out_res_in;
   result_type res;
   logic       advance;
   logic       step;
   logic       req_take;

   // register writes
   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_DESIRED:   cfg_in.target_dist         = csr_chan.data;
            CSR_MARGIN:    cfg_in.margin              = csr_chan.data;
            CSR_TOO_CLOSE: cfg_in.too_close_limit     = csr_chan.data;
            CSR_ROTATE:    cfg_in.rotate_threshold    = csr_chan.data;
            CSR_MPW:       cfg_in.messages_per_window = csr_chan.data[MPW_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   // two-stage pipeline with stall from the result side
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign step           = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in  = req_chan.ready ? req_chan.valid : in_valid_ff;
      in_item_in   = in_item_ff;
      if (req_take) begin
         in_item_in.func            = req_chan.func;
         in_item_in.distance_sample = req_chan.distance_sample;
      end
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
      out_res_in   = step ? res : out_res_ff;
   end

   ofc_engine u_engine (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (in_item_ff),
      .cfg   (cfg_ff),
      .res   (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_dist         <= RST_DESIRED;
         cfg_ff.margin              <= RST_MARGIN;
         cfg_ff.too_close_limit     <= RST_TOO_CLOSE;
         cfg_ff.rotate_threshold    <= RST_ROTATE;
         cfg_ff.messages_per_window <= RST_MPW;
         in_valid_ff                <= 1'b0;
         out_valid_ff               <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.move_cmd  = out_res_ff.move_cmd;
   assign rsp_chan.led_color = out_res_ff.led_color;
   assign rsp_chan.mode      = out_res_ff.mode;

   `OFC_ASSERT(a_fwd_only_in_escape, clock, reset, out_valid_ff && out_res_ff.move_cmd == MV_FWD |-> out_res_ff.mode == ST_MEAS_ESC, "forward move outside escape")

endmodule
